// ===== sv/r10a2_pkg.sv =====
// Package for the RGB10_A2 pixel packer: beat structs, format codes and
// shared widths. No dependencies.
`default_nettype none
package r10a2_pkg;

    typedef logic [1:0] t_fmt;

    localparam t_fmt FMT_UNORM8   = 2'd0;
    localparam t_fmt FMT_HALF     = 2'd1;
    localparam t_fmt FMT_SINGLE   = 2'd2;
    // unused code: packs a zero word
    localparam t_fmt FMT_RESERVED = 2'd3;

    localparam logic [9:0] COLOR_MAX = 10'd1023;
    localparam logic [9:0] ALPHA_MAX = 10'd3;

    // 24-bit significand times a 10-bit scale
    localparam int MANT_W = 24;
    localparam int PROD_W = 34;
    localparam int SH_W   = 6;
    // right shifts beyond this always round to zero
    localparam logic signed [9:0] MAX_SH = 10'sd35;

    typedef struct packed {
        logic [31:0] component_0;
        logic [31:0] component_1;
        logic [31:0] component_2;
        logic [31:0] component_3;
        logic        end_of_row;
    } t_pix_in;

    typedef struct packed {
        logic [31:0] packed_pixel;
        logic        row_done;
    } t_pix_out;

    typedef struct packed {
        logic adv1;
        logic adv2;
    } t_pipe_ctl;

endpackage
`default_nettype wire

// ===== sv/pixel_to_rgb10a2_packer_top.sv =====
// Top level of the RGB10_A2 pixel packer: handshakes, format register,
// four conversion lanes and the merge stage. Depends on r10a2_pkg,
// r10a2_lane and r10a2_merge.
//
// Packs one four-component pixel per beat into a 32-bit RGB10_A2 word:
// component 3 (alpha) lands in bits 31:30, components 2, 1, 0 in 29:20,
// 19:10 and 9:0. The format register (write beat on the cfg channel,
// reset 0) picks 8-bit unorm, IEEE half or IEEE single sources; code 3
// yields a zero word. Float values are scaled exactly by 1023 (color) or
// 3 (alpha), rounded to nearest with ties away from zero and clamped;
// negatives and NaN give 0, +inf saturates. end_of_row rides along as
// row_done. Throughput is one pixel per clock while the output is not
// stalled. Each word passes the lane register, which holds each lane's
// scale product, then the packed output register. Four lanes run in
// parallel, one per component. Change the format only while the
// pipeline is empty.
`default_nettype none
module pixel_to_rgb10a2_packer_top (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_pix_valid,
    output logic                    o_pix_ready,
    input  wire r10a2_pkg::t_pix_in i_pix,
    output logic                    o_word_valid,
    input  wire                     i_word_ready,
    output r10a2_pkg::t_pix_out     o_word,
    input  wire                     i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire r10a2_pkg::t_fmt    i_cfg_data
);

    r10a2_pkg::t_fmt      r_fmt, n_fmt;
    logic                 r_v1, n_v1;
    logic                 r_v2, n_v2;
    logic                 r_row1;
    r10a2_pkg::t_pipe_ctl l_ctl;
    logic [9:0]           l_c0, l_c1, l_c2, l_a;

    // Advance stage 2 whenever the output register is free or draining;
    // stage 1 takes a new beat whenever it is empty or moving on.
    always_comb begin
        l_ctl.adv2  = r_v1 && (!r_v2 || i_word_ready);
        o_pix_ready = !r_v1 || l_ctl.adv2;
        l_ctl.adv1  = i_pix_valid && o_pix_ready;
        o_cfg_ready = 1'b1;
        n_fmt       = (i_cfg_valid) ? i_cfg_data : r_fmt;
        n_v1        = l_ctl.adv1 || (r_v1 && !l_ctl.adv2);
        n_v2        = l_ctl.adv2 || (r_v2 && !i_word_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= r10a2_pkg::FMT_UNORM8;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
        end else begin
            r_fmt <= n_fmt;
            r_v1  <= n_v1;
            r_v2  <= n_v2;
        end
    end

    // Hold the row flag alongside the lane products.
    always_ff @(posedge i_clk) begin
        if (l_ctl.adv1) begin
            r_row1 <= i_pix.end_of_row;
        end
    end

    r10a2_lane #(.P_ALPHA(1'b0)) u_lane0 (
        .i_clk   (i_clk),
        .i_en    (l_ctl.adv1),
        .i_fmt   (r_fmt),
        .i_raw   (i_pix.component_0),
        .o_value (l_c0)
    );

    r10a2_lane #(.P_ALPHA(1'b0)) u_lane1 (
        .i_clk   (i_clk),
        .i_en    (l_ctl.adv1),
        .i_fmt   (r_fmt),
        .i_raw   (i_pix.component_1),
        .o_value (l_c1)
    );

    r10a2_lane #(.P_ALPHA(1'b0)) u_lane2 (
        .i_clk   (i_clk),
        .i_en    (l_ctl.adv1),
        .i_fmt   (r_fmt),
        .i_raw   (i_pix.component_2),
        .o_value (l_c2)
    );

    r10a2_lane #(.P_ALPHA(1'b1)) u_lane3 (
        .i_clk   (i_clk),
        .i_en    (l_ctl.adv1),
        .i_fmt   (r_fmt),
        .i_raw   (i_pix.component_3),
        .o_value (l_a)
    );

    r10a2_merge u_merge (
        .i_clk  (i_clk),
        .i_ctl  (l_ctl),
        .i_c0   (l_c0),
        .i_c1   (l_c1),
        .i_c2   (l_c2),
        .i_a    (l_a),
        .i_row  (r_row1),
        .o_beat (o_word)
    );

    assign o_word_valid = r_v2;

`ifndef SYNTH
    // An empty first stage must always take a beat.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 |-> o_pix_ready)
        else $error("input stalled with empty stage 1");

    // An accepted beat fills stage 1.
    a_fill_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        l_ctl.adv1 |=> r_v1)
        else $error("accepted beat lost in stage 1");

    // The reserved format code packs a zero word.
    a_reserved_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (l_ctl.adv2 && r_fmt == r10a2_pkg::FMT_RESERVED && !i_cfg_valid)
        |=> o_word.packed_pixel == 32'd0)
        else $error("reserved format gave nonzero word");

    // Unorm color is value times four, so the low color bits stay clear.
    a_unorm_low_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (l_ctl.adv2 && r_fmt == r10a2_pkg::FMT_UNORM8 && !i_cfg_valid)
        |=> o_word.packed_pixel[1:0] == 2'b00)
        else $error("unorm color has low bits set");
`endif

endmodule
`default_nettype wire

// ===== sv/r10a2_lane.sv =====
// One component lane: decode, scale multiply (registered), then round,
// shift and clamp. Depends on r10a2_pkg.
`default_nettype none
module r10a2_lane #(
    parameter bit P_ALPHA = 1'b0
) (
    input  wire                   i_clk,
    input  wire                   i_en,
    input  wire r10a2_pkg::t_fmt  i_fmt,
    input  wire [31:0]            i_raw,
    output logic [9:0]            o_value
);

    localparam logic [9:0] L_SCALE = P_ALPHA ? r10a2_pkg::ALPHA_MAX : r10a2_pkg::COLOR_MAX;

    logic [r10a2_pkg::PROD_W-1:0] r_prod, n_prod;
    logic [r10a2_pkg::SH_W-1:0]   r_sh, n_sh;
    logic                         r_zero, n_zero;
    logic                         r_sat, n_sat;
    logic                         r_direct, n_direct;
    logic [9:0]                   r_dval, n_dval;

    logic [r10a2_pkg::MANT_W-1:0] l_mant;
    logic signed [9:0]            l_exp;
    logic signed [9:0]            l_nexp;
    logic                         l_neg;
    logic                         l_special;
    logic                         l_frac_nz;
    logic [9:0]                   l_unorm_a;

    always_comb begin
        l_mant    = '0;
        l_exp     = '0;
        l_neg     = 1'b0;
        l_special = 1'b0;
        l_frac_nz = 1'b0;
        n_direct  = 1'b0;
        n_dval    = '0;
        l_unorm_a = {2'b00, i_raw[7:0]} * 10'd3 + 10'd127;
        unique case (i_fmt)
            r10a2_pkg::FMT_UNORM8: begin
                n_direct = 1'b1;
                n_dval   = P_ALPHA ? {8'd0, l_unorm_a[9:8]} : {i_raw[7:0], 2'b00};
            end
            r10a2_pkg::FMT_HALF: begin
                l_neg     = i_raw[15];
                l_special = (i_raw[14:10] == 5'h1f);
                l_frac_nz = (i_raw[9:0] != '0);
                if (i_raw[14:10] == 5'd0) begin
                    l_mant = {14'd0, i_raw[9:0]};
                    l_exp  = -10'sd24;
                end else begin
                    l_mant = {13'd0, 1'b1, i_raw[9:0]};
                    l_exp  = $signed({5'd0, i_raw[14:10]}) - 10'sd25;
                end
            end
            r10a2_pkg::FMT_SINGLE: begin
                l_neg     = i_raw[31];
                l_special = (i_raw[30:23] == 8'hff);
                l_frac_nz = (i_raw[22:0] != '0);
                if (i_raw[30:23] == 8'd0) begin
                    l_mant = {1'b0, i_raw[22:0]};
                    l_exp  = -10'sd149;
                end else begin
                    l_mant = {1'b1, i_raw[22:0]};
                    l_exp  = $signed({2'd0, i_raw[30:23]}) - 10'sd150;
                end
            end
            default: begin
                n_direct = 1'b1;
            end
        endcase

        l_nexp = -l_exp;
        n_sh   = l_nexp[r10a2_pkg::SH_W-1:0];
        n_prod = {10'd0, l_mant} * {24'd0, L_SCALE};
        // NaN, negatives and zero drop to 0; +inf and any value >= 1 saturate
        if (l_special) begin
            n_zero = l_neg || l_frac_nz;
            n_sat  = !(l_neg || l_frac_nz);
        end else begin
            n_zero = l_neg || (l_mant == '0) || (l_nexp > r10a2_pkg::MAX_SH);
            n_sat  = !(l_neg || (l_mant == '0)) && (l_exp >= 10'sd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod   <= n_prod;
            r_sh     <= n_sh;
            r_zero   <= n_zero;
            r_sat    <= n_sat;
            r_direct <= n_direct;
            r_dval   <= n_dval;
        end
    end

    logic [r10a2_pkg::PROD_W-1:0] l_t;
    logic [r10a2_pkg::PROD_W:0]   l_q;

    always_comb begin
        // round half away: keep one extra bit, add one, drop it
        l_t = r_prod >> (r_sh - 6'd1);
        l_q = ({1'b0, l_t} + 35'd1) >> 1;
        priority if (r_direct) begin
            o_value = r_dval;
        end else if (r_zero) begin
            o_value = '0;
        end else if (r_sat || (l_q > {25'd0, L_SCALE})) begin
            o_value = L_SCALE;
        end else begin
            o_value = l_q[9:0];
        end
    end

endmodule
`default_nettype wire

// ===== sv/r10a2_merge.sv =====
// Merge stage: packs the four lane results and the row flag into the
// output register. Depends on r10a2_pkg.
`default_nettype none
module r10a2_merge (
    input  wire                        i_clk,
    input  wire r10a2_pkg::t_pipe_ctl  i_ctl,
    input  wire [9:0]                  i_c0,
    input  wire [9:0]                  i_c1,
    input  wire [9:0]                  i_c2,
    input  wire [9:0]                  i_a,
    input  wire                        i_row,
    output r10a2_pkg::t_pix_out        o_beat
);

    r10a2_pkg::t_pix_out r_beat, n_beat;

    always_comb begin
        n_beat.packed_pixel = {i_a[1:0], i_c2, i_c1, i_c0};
        n_beat.row_done     = i_row;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv2) begin
            r_beat <= n_beat;
        end
    end

    assign o_beat = r_beat;

endmodule
`default_nettype wire

// ===== tb/pixel_to_rgb10a2_packer_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench for pixel_to_rgb10a2_packer_top: drives pixel beats over all source
// formats and checks every packed word against a behavioral converter.
// Depends on r10a2_pkg and the packer RTL.

// Tracks the format register and the words the packer owes, oldest first.
class word_scoreboard;
    r10a2_pkg::t_fmt     fmt;
    r10a2_pkg::t_pix_out pending_words[$];
    int unsigned         mismatches;

    function new();
        fmt = r10a2_pkg::FMT_UNORM8;
        mismatches = 0;
    endfunction

    // Round half away from zero of mant * 2^exp2 * scale, clamped to 0..scale.
    function logic [9:0] round_scaled(bit neg, longint unsigned mant, int exp2,
                                      int unsigned scale);
        longint unsigned prod;
        longint unsigned q;
        int unsigned     sh;
        if (neg || mant == 0)
            return 10'd0;
        prod = mant * scale;
        if (exp2 >= 0) begin
            if (exp2 >= 11)
                return scale[9:0];
            q = prod << exp2;
        end else begin
            sh = -exp2;
            if (sh >= 63)
                return 10'd0;
            q = (prod + (64'd1 << (sh - 1))) >> sh;
        end
        return (q > scale) ? scale[9:0] : q[9:0];
    endfunction

    function logic [9:0] convert_component(logic [31:0] raw, bit is_alpha);
        int unsigned scale;
        int unsigned b;
        scale = is_alpha ? r10a2_pkg::ALPHA_MAX : r10a2_pkg::COLOR_MAX;
        case (fmt)
            r10a2_pkg::FMT_UNORM8: begin
                b = raw[7:0];
                return is_alpha ? 10'((b * 3 + 127) >> 8) : 10'(b * 4);
            end
            r10a2_pkg::FMT_HALF: begin
                // NaN, and inf of either sign
                if (raw[14:10] == 5'h1F)
                    return (raw[9:0] != 0 || raw[15]) ? 10'd0 : scale[9:0];
                if (raw[14:10] == 5'h00)
                    return round_scaled(raw[15], raw[9:0], -24, scale);
                return round_scaled(raw[15], {1'b1, raw[9:0]},
                                    int'(raw[14:10]) - 25, scale);
            end
            r10a2_pkg::FMT_SINGLE: begin
                if (raw[30:23] == 8'hFF)
                    return (raw[22:0] != 0 || raw[31]) ? 10'd0 : scale[9:0];
                if (raw[30:23] == 8'h00)
                    return round_scaled(raw[31], raw[22:0], -149, scale);
                return round_scaled(raw[31], {1'b1, raw[22:0]},
                                    int'(raw[30:23]) - 150, scale);
            end
            default: return 10'd0;
        endcase
    endfunction

    function void note_pixel(r10a2_pkg::t_pix_in px);
        r10a2_pkg::t_pix_out w;
        logic [9:0] a;
        a = convert_component(px.component_3, 1'b1);
        w.packed_pixel = {a[1:0],
                          convert_component(px.component_2, 1'b0),
                          convert_component(px.component_1, 1'b0),
                          convert_component(px.component_0, 1'b0)};
        w.row_done = px.end_of_row;
        pending_words.push_back(w);
    endfunction

    function void check_word(r10a2_pkg::t_pix_out got);
        r10a2_pkg::t_pix_out exp_w;
        if (pending_words.size() == 0) begin
            $error("word beat with nothing pending: packed_pixel %h", got.packed_pixel);
            mismatches++;
            return;
        end
        exp_w = pending_words.pop_front();
        if (got.packed_pixel !== exp_w.packed_pixel) begin
            $error("packed_pixel: expected %h, got %h", exp_w.packed_pixel,
                   got.packed_pixel);
            mismatches++;
        end
        if (got.row_done !== exp_w.row_done) begin
            $error("row_done: expected %b, got %b", exp_w.row_done, got.row_done);
            mismatches++;
        end
    endfunction
endclass

module pixel_to_rgb10a2_packer_top_tb;

    localparam int              CLK_PERIOD     = 12;
    localparam int              TIMEOUT_CYCLES = 200_000;
    localparam int              HOLD_CYCLES    = 150;
    localparam r10a2_pkg::t_fmt FMT_UNUSED     = r10a2_pkg::FMT_RESERVED;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_pix_valid;
    logic                o_pix_ready;
    r10a2_pkg::t_pix_in  i_pix;
    logic                o_word_valid;
    logic                i_word_ready;
    r10a2_pkg::t_pix_out o_word;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    r10a2_pkg::t_fmt     i_cfg_data;

    word_scoreboard board = new();

    // Idle rates in percent; the main sequence sets them per phase.
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    // The main sequence bumps this to ask the receiver for one long hold-off.
    int unsigned hold_requests = 0;

    // Special values per format, rotated through all four component slots.
    // Upper bits carry junk where the format ignores them.
    logic [31:0] unorm_specials[$] = '{32'hDEAD_BE00, 32'h0000_00FF, 32'h1234_562A,
                                       32'hFFFF_FF2B, 32'h0000_0080, 32'hA5A5_A581,
                                       32'h5A5A_5AD5, 32'h0000_00D6};
    logic [31:0] half_specials[$]  = '{32'h0000_0000, 32'hFFFF_8000, 32'h0000_7C00,
                                       32'h1234_FC00, 32'h0000_7E00, 32'hFFFF_3800,
                                       32'h0000_0001, 32'hA5A5_7BFF, 32'h0000_3C00};
    logic [31:0] single_specials[$] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
                                        32'hFF80_0000, 32'hFFC0_0001, 32'h3F00_0000,
                                        32'h0000_0001, 32'h7F7F_FFFF, 32'h3F80_0000};

    pixel_to_rgb10a2_packer_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (i_pix_valid),
        .o_pix_ready (o_pix_ready),
        .i_pix       (i_pix),
        .o_word_valid(o_word_valid),
        .i_word_ready(i_word_ready),
        .o_word      (o_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("** pixel_to_rgb10a2_packer_top: FAILED **");
        $finish;
    end

    // Receiver: pick ready at each falling edge. A hold-off request drops ready
    // for one long hold-off so the pipeline backs up into the input.
    initial begin : word_sink
        int unsigned hold_left;
        int unsigned holds_served;
        hold_left = 0;
        holds_served = 0;
        i_word_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_requests != holds_served) begin
                holds_served = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_word_ready = 1'b0;
            end else begin
                i_word_ready = ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Check each output beat at the edge that takes it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_word_valid && i_word_ready)
            board.check_word(o_word);
    end

    // Biased source values: mostly in the range where rounding matters, with
    // some negatives, NaN/inf, subnormals and fully random words mixed in.
    function automatic logic [31:0] random_component(r10a2_pkg::t_fmt f);
        logic [31:0] r;
        int unsigned pick;
        int unsigned e;
        r = $urandom();
        pick = $urandom_range(9);
        if (pick < 2)
            return r;
        case (f)
            r10a2_pkg::FMT_HALF: begin
                e = (pick == 3) ? 5'h1F : (pick == 4) ? 5'h00 : $urandom_range(15, 5);
                r[15] = (pick == 2);
                r[14:10] = e[4:0];
            end
            r10a2_pkg::FMT_SINGLE: begin
                e = (pick == 3) ? 8'hFF : (pick == 4) ? 8'h00 : $urandom_range(128, 108);
                r[31] = (pick == 2);
                r[30:23] = e[7:0];
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic r10a2_pkg::t_pix_in random_pixel(r10a2_pkg::t_fmt f);
        r10a2_pkg::t_pix_in px;
        px.component_0 = random_component(f);
        px.component_1 = random_component(f);
        px.component_2 = random_component(f);
        px.component_3 = random_component(f);
        px.end_of_row  = ($urandom_range(7) == 0);
        return px;
    endfunction

    // Offer one pixel beat; entered and left at a falling edge.
    task automatic send_pixel(input r10a2_pkg::t_pix_in px);
        while ($urandom_range(99) < send_idle_pct) begin
            i_pix_valid = 1'b0;
            @(negedge i_clk);
        end
        i_pix_valid = 1'b1;
        i_pix = px;
        do @(posedge i_clk); while (!o_pix_ready);
        board.note_pixel(px);
        @(negedge i_clk);
    endtask

    task automatic send_rotations(input logic [31:0] vals[$]);
        r10a2_pkg::t_pix_in px;
        int n;
        n = vals.size();
        for (int i = 0; i < n; i++) begin
            px.component_0 = vals[i];
            px.component_1 = vals[(i + 1) % n];
            px.component_2 = vals[(i + 2) % n];
            px.component_3 = vals[(i + 3) % n];
            px.end_of_row  = i[0];
            send_pixel(px);
        end
    endtask

    // Pause the sender until every owed word is back, then let the pipe settle.
    task automatic drain_words();
        i_pix_valid = 1'b0;
        while (board.pending_words.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Write the format register; only called with the pipeline empty.
    task automatic write_format(input r10a2_pkg::t_fmt f);
        drain_words();
        i_cfg_valid = 1'b1;
        i_cfg_data = f;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.fmt = f;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    initial begin : main_seq
        r10a2_pkg::t_fmt phase_fmts[4];
        int unsigned phase_send[4];
        int unsigned phase_stall[4];
        int unsigned count;

        phase_fmts  = '{r10a2_pkg::FMT_UNORM8, r10a2_pkg::FMT_HALF,
                        r10a2_pkg::FMT_SINGLE, FMT_UNUSED};
        // no idling, sender idle, receiver stalling, both lightly
        phase_send  = '{0, 70, 0, 13};
        phase_stall = '{0, 0, 70, 13};

        i_rst_n     = 1'b0;
        i_pix_valid = 1'b0;
        i_pix       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = r10a2_pkg::FMT_UNORM8;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: format thresholds and special encodings, reset format first.
        send_rotations(unorm_specials);
        write_format(r10a2_pkg::FMT_HALF);
        send_rotations(half_specials);
        write_format(r10a2_pkg::FMT_SINGLE);
        send_rotations(single_specials);
        write_format(FMT_UNUSED);
        repeat (2) send_pixel(random_pixel(FMT_UNUSED));

        // Random: every idling mode against every format.
        for (int m = 0; m < 4; m++) begin
            for (int k = 0; k < 4; k++) begin
                write_format(phase_fmts[k]);
                send_idle_pct = phase_send[m];
                stall_pct = phase_stall[m];
                count = (phase_fmts[k] == FMT_UNUSED) ? 10 : 50;
                // Back up the pipe once: hold the receiver off while beats keep coming.
                if (m == 0 && phase_fmts[k] == r10a2_pkg::FMT_HALF)
                    hold_requests++;
                repeat (count) send_pixel(random_pixel(phase_fmts[k]));
            end
        end

        drain_words();
        repeat (10) @(posedge i_clk);
        if (board.mismatches == 0)
            $display("** pixel_to_rgb10a2_packer_top: PASSED **");
        else
            $display("** pixel_to_rgb10a2_packer_top: FAILED **");
        $finish;
    end

endmodule
